@@ hdl/lmss_pkg.sv @@
// Shared types and constants for the LED matrix scroll scanner.
package lmss_pkg;

  localparam int unsigned MatrixSize = 8;
  localparam int unsigned ColW       = 3;
  localparam int unsigned OffsetW    = 8;
  localparam int unsigned RowW       = 8;
  localparam int unsigned RepeatW    = 8;
  localparam int unsigned LenW       = 9;
  localparam int unsigned CfgDataW   = 9;

  typedef enum logic [0:0] {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_type_e;

  typedef enum logic [0:0] {
    CFG_FRAME_REPEATS = 1'b0,
    CFG_LINE_LENGTH   = 1'b1
  } cfg_index_e;

  // Per-tick scan status handed from the counters to the output stage.
  typedef struct packed {
    logic [ColW-1:0]    col;
    logic [OffsetW-1:0] offset;
    logic               frame_end;
    logic               wrapped;
  } scan_t;

endpackage

@@ hdl/lmss_scan_ctrl.sv @@
// Column, frame and window offset counters of the scroll scanner.
module lmss_scan_ctrl import lmss_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  logic               hold_i,
  input  logic [RepeatW-1:0] frame_repeats_i,
  input  logic [LenW-1:0]    line_length_i,
  output scan_t              scan_o
);

  localparam int unsigned CapInt = (LINE_DEPTH < 256) ? LINE_DEPTH : 256;
  localparam logic [LenW-1:0] LenCap = LenW'(CapInt);
  localparam logic [LenW-1:0] LenMin = LenW'(MatrixSize);
  localparam logic [ColW-1:0] LastCol = ColW'(MatrixSize - 1);

  logic [ColW-1:0]    col_q, col_d;
  logic [RepeatW-1:0] frame_count_q, frame_count_d;
  logic [OffsetW-1:0] offset_q, offset_d;

  logic [RepeatW-1:0] repeats;
  logic [RepeatW-1:0] count_inc;
  logic [LenW-1:0]    len_eff;
  logic [LenW-1:0]    wrap_limit;
  logic               last_col;
  logic               step;
  logic               wrap;

  always_comb begin
    priority if (line_length_i > LenCap) begin
      len_eff = LenCap;
    end else if (line_length_i < LenMin) begin
      len_eff = LenMin;
    end else begin
      len_eff = line_length_i;
    end
    wrap_limit = len_eff - LenMin;
    repeats    = (frame_repeats_i == '0) ? RepeatW'(1) : frame_repeats_i;
    count_inc  = frame_count_q + RepeatW'(1);
    last_col   = (col_q == LastCol);
    step       = last_col && (count_inc >= repeats);
    wrap       = step && !hold_i && ({1'b0, offset_q} >= wrap_limit);
  end

  always_comb begin
    col_d         = col_q;
    frame_count_d = frame_count_q;
    offset_d      = offset_q;
    if (tick_i) begin
      col_d = last_col ? '0 : col_q + ColW'(1);
      if (last_col) begin
        frame_count_d = step ? '0 : count_inc;
      end
      if (step && !hold_i) begin
        offset_d = wrap ? '0 : offset_q + OffsetW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q         <= '0;
      frame_count_q <= '0;
      offset_q      <= '0;
    end else begin
      col_q         <= col_d;
      frame_count_q <= frame_count_d;
      offset_q      <= offset_d;
    end
  end

  // Status of the tick being accepted, before the counters move.
  assign scan_o.col       = col_q;
  assign scan_o.offset    = offset_q;
  assign scan_o.frame_end = last_col;
  assign scan_o.wrapped   = wrap;

endmodule

@@ hdl/led_matrix_scroll_scanner.sv @@
// Top level of the 8x8 LED matrix scroll scanner with its line store.
//
// Every start beat is taken at once: busy_o stays low, one item per clock.
// A load beat writes one column byte into the line store and gives no result.
// A tick beat reads the store at window offset plus column; the store read is
// synchronous and registered, so the result shows on the output ports in the
// cycle after the tick, for one cycle, with result_strobe_o high.
// The output register is separate from the counters, so a new beat may be
// taken in the cycle a result is shown. Results cannot be held off. Store
// entries read before any load wrote them give undefined row bits; a window
// position at or past the store depth reads as zero. Configuration writes
// through cfg_we_i act on the next tick.
module led_matrix_scroll_scanner import lmss_pkg::*; #(
  parameter int unsigned LINE_DEPTH = 256
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  req_type_i,
  input  logic [7:0]            load_index_i,
  input  logic [RowW-1:0]       column_data_i,
  input  logic                  hold_i,
  input  logic                  cfg_we_i,
  input  logic                  cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_data_i,
  output logic                  result_strobe_o,
  output logic [MatrixSize-1:0] column_select_n_o,
  output logic [RowW-1:0]       row_bits_o,
  output logic                  frame_end_o,
  output logic                  scroll_wrapped_o
);

  localparam int unsigned AddrW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  logic [RepeatW-1:0] frame_repeats_q;
  logic [LenW-1:0]    line_length_q;

  logic      accept;
  logic      tick;
  logic      load;
  req_type_e req;
  scan_t     scan;

  logic [OffsetW:0]   rd_sum;
  logic               rd_in_range;
  logic               wr_in_range;
  logic [AddrW-1:0]   rd_addr;
  logic [AddrW-1:0]   wr_addr;

  logic [RowW-1:0] line_mem [LINE_DEPTH];
  logic [RowW-1:0] rd_data_q;

  logic                   strobe_q;
  logic                   in_range_q;
  logic [ColW-1:0]        col_q;
  logic                   frame_end_q;
  logic                   wrapped_q;

  // No item ever waits: ticks and loads both complete in their beat.
  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign req    = req_type_e'(req_type_i);
  assign tick   = accept && (req == REQ_TICK);
  assign load   = accept && (req == REQ_LOAD);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_repeats_q <= RepeatW'(10);
      line_length_q   <= LenW'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_FRAME_REPEATS: frame_repeats_q <= cfg_data_i[RepeatW-1:0];
        CFG_LINE_LENGTH:   line_length_q   <= cfg_data_i[LenW-1:0];
      endcase
    end
  end

  lmss_scan_ctrl #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_scan_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .tick_i          (tick),
    .hold_i          (hold_i),
    .frame_repeats_i (frame_repeats_q),
    .line_length_i   (line_length_q),
    .scan_o          (scan)
  );

  always_comb begin
    rd_sum      = {1'b0, scan.offset} + (OffsetW+1)'(scan.col);
    rd_in_range = (32'(rd_sum) < LINE_DEPTH);
    wr_in_range = (32'(load_index_i) < LINE_DEPTH);
    rd_addr     = AddrW'(rd_sum);
    wr_addr     = AddrW'(load_index_i);
  end

  // Line store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (load && wr_in_range) begin
      line_mem[wr_addr] <= column_data_i;
    end
    if (tick && rd_in_range) begin
      rd_data_q <= line_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strobe_q <= 1'b0;
    end else begin
      strobe_q <= tick;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tick) begin
      in_range_q  <= rd_in_range;
      col_q       <= scan.col;
      frame_end_q <= scan.frame_end;
      wrapped_q   <= scan.wrapped;
    end
  end

  assign result_strobe_o   = strobe_q;
  assign column_select_n_o = ~(MatrixSize'(1) << col_q);
  assign row_bits_o        = in_range_q ? rd_data_q : '0;
  assign frame_end_o       = frame_end_q;
  assign scroll_wrapped_o  = wrapped_q;

endmodule

@@ tb/tb_led_matrix_scroll_scanner.sv @@
// Self-checking testbench for the LED matrix scroll scanner: directed table, then random phases.
`timescale 1ns / 1ps

module tb_led_matrix_scroll_scanner import lmss_pkg::*; ();

  localparam int unsigned LineDepth  = 256;
  localparam int unsigned NumDir     = 19;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned PhaseBeats = 160;
  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] sel_n;
    logic [7:0] rows;
    logic       frame_end;
    logic       wrapped;
  } scan_result_t;

  typedef struct packed {
    req_type_e    req;
    logic [7:0]   idx;
    logic [7:0]   data;
    logic         hold;
    logic         typed;
    scan_result_t res;
  } stim_row_t;

  // After reset: repeats 10, length 8, so nothing scrolls within one frame.
  localparam stim_row_t DirRows [NumDir] = '{
    '{REQ_LOAD, 8'd0,   8'h00, 1'b0, 1'b0, '0},
    '{REQ_LOAD, 8'd1,   8'hFF, 1'b1, 1'b0, '0},
    '{REQ_LOAD, 8'd2,   8'h01, 1'b0, 1'b0, '0},
    '{REQ_LOAD, 8'd3,   8'h80, 1'b0, 1'b0, '0},
    '{REQ_LOAD, 8'd4,   8'hA5, 1'b0, 1'b0, '0},
    '{REQ_LOAD, 8'd5,   8'h5A, 1'b0, 1'b0, '0},
    '{REQ_LOAD, 8'd6,   8'h0F, 1'b0, 1'b0, '0},
    '{REQ_LOAD, 8'd7,   8'hF0, 1'b0, 1'b0, '0},
    '{REQ_LOAD, 8'd255, 8'h3C, 1'b0, 1'b0, '0},
    '{REQ_TICK, 8'hFF,  8'hFF, 1'b0, 1'b1, '{8'hFE, 8'h00, 1'b0, 1'b0}},
    '{REQ_TICK, 8'h00,  8'h00, 1'b1, 1'b1, '{8'hFD, 8'hFF, 1'b0, 1'b0}},
    '{REQ_TICK, 8'hFF,  8'hFF, 1'b0, 1'b1, '{8'hFB, 8'h01, 1'b0, 1'b0}},
    '{REQ_TICK, 8'h00,  8'h00, 1'b1, 1'b1, '{8'hF7, 8'h80, 1'b0, 1'b0}},
    '{REQ_TICK, 8'hFF,  8'hFF, 1'b0, 1'b1, '{8'hEF, 8'hA5, 1'b0, 1'b0}},
    '{REQ_TICK, 8'h00,  8'h00, 1'b1, 1'b1, '{8'hDF, 8'h5A, 1'b0, 1'b0}},
    '{REQ_TICK, 8'hFF,  8'hFF, 1'b0, 1'b1, '{8'hBF, 8'h0F, 1'b0, 1'b0}},
    '{REQ_TICK, 8'h00,  8'h00, 1'b1, 1'b1, '{8'h7F, 8'hF0, 1'b1, 1'b0}},
    '{REQ_LOAD, 8'd0,   8'hC3, 1'b1, 1'b0, '0},
    '{REQ_TICK, 8'h00,  8'h00, 1'b0, 1'b1, '{8'hFE, 8'hC3, 1'b0, 1'b0}}
  };

  // Register settings per random phase; the last phase is drawn at random.
  // 0 repeats acts as 1, bit 8 of the repeats data is dropped, lengths clamp to 8..256.
  localparam logic [8:0] PhRepeats [NumPhases] = '{
    9'd1, 9'd0, 9'd255, 9'h101, 9'd2, 9'd3, 9'd1, 9'd0
  };
  localparam logic [8:0] PhLength [NumPhases] = '{
    9'd9, 9'd511, 9'd8, 9'd0, 9'd16, 9'd40, 9'd12, 9'd0
  };

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic                req_type_i;
  logic [7:0]          load_index_i;
  logic [RowW-1:0]     column_data_i;
  logic                hold_i;
  logic                cfg_we_i;
  logic                cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic                result_strobe_o;
  logic [7:0]          column_select_n_o;
  logic [RowW-1:0]     row_bits_o;
  logic                frame_end_o;
  logic                scroll_wrapped_o;

  led_matrix_scroll_scanner u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .load_index_i     (load_index_i),
    .column_data_i    (column_data_i),
    .hold_i           (hold_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .result_strobe_o  (result_strobe_o),
    .column_select_n_o(column_select_n_o),
    .row_bits_o       (row_bits_o),
    .frame_end_o      (frame_end_o),
    .scroll_wrapped_o (scroll_wrapped_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Scanner state as the predictor sees it.
  logic [7:0]      col_bytes [LineDepth];
  bit              col_loaded [LineDepth];
  logic [ColW-1:0] scan_col;
  logic [7:0]      frames_shown;
  logic [7:0]      window_pos;
  logic [7:0]      repeats_reg;
  logic [8:0]      length_reg;

  scan_result_t    pending_scans [$];
  int unsigned     err_cnt;
  int unsigned     beat_cnt;
  int unsigned     cyc_cnt;

  function automatic int unsigned clamped_length();
    int unsigned len;
    len = length_reg;
    if (len > LineDepth) len = LineDepth;
    if (len < MatrixSize) len = MatrixSize;
    return len;
  endfunction

  function automatic scan_result_t scan_tick(input logic hold);
    scan_result_t res;
    int unsigned  addr;
    logic [7:0]   reps;
    addr          = int'(window_pos) + int'(scan_col);
    res.sel_n     = ~(8'b1 << scan_col);
    res.rows      = (addr < LineDepth) ? col_bytes[addr] : 8'h00;
    res.frame_end = 1'b0;
    res.wrapped   = 1'b0;
    if (scan_col == ColW'(MatrixSize - 1)) begin
      res.frame_end = 1'b1;
      scan_col      = '0;
      reps          = (repeats_reg == 8'd0) ? 8'd1 : repeats_reg;
      frames_shown  = frames_shown + 8'd1;
      if (frames_shown >= reps) begin
        frames_shown = '0;
        if (!hold) begin
          if (int'(window_pos) >= clamped_length() - MatrixSize) begin
            window_pos  = '0;
            res.wrapped = 1'b1;
          end else begin
            window_pos = window_pos + 8'd1;
          end
        end
      end
    end else begin
      scan_col = scan_col + 1'b1;
    end
    return res;
  endfunction

  function automatic int unsigned sender_idle_pct();
    if (beat_cnt < 430) return 20;
    if (beat_cnt < 860) return 77;
    return 0;
  endfunction

  // Random beat; a tick that would read a never-loaded column becomes a load of it.
  function automatic stim_row_t random_beat();
    stim_row_t   r;
    int unsigned addr;
    r.req   = ($urandom_range(99) < 25) ? REQ_LOAD : REQ_TICK;
    r.idx   = 8'($urandom_range(255));
    r.data  = 8'($urandom_range(255));
    r.hold  = ($urandom_range(99) < 15);
    r.typed = 1'b0;
    r.res   = '0;
    addr    = int'(window_pos) + int'(scan_col);
    if (r.req == REQ_TICK && addr < LineDepth && !col_loaded[addr]) begin
      r.req = REQ_LOAD;
      r.idx = addr[7:0];
    end
    return r;
  endfunction

  task automatic idle_gap();
    while ($urandom_range(99) < sender_idle_pct()) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_beat(input stim_row_t row);
    scan_result_t res;
    start_i       <= 1'b1;
    req_type_i    <= row.req;
    load_index_i  <= row.idx;
    column_data_i <= row.data;
    hold_i        <= row.hold;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    if (row.req == REQ_LOAD) begin
      col_bytes[row.idx]  = row.data;
      col_loaded[row.idx] = 1'b1;
    end else begin
      res = scan_tick(row.hold);
      pending_scans.push_back(row.typed ? row.res : res);
    end
    beat_cnt++;
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending_scans.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [8:0] reps, input logic [8:0] len);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_FRAME_REPEATS;
    cfg_data_i  <= reps;
    @(posedge clk_i);
    repeats_reg = reps[7:0];
    cfg_index_i <= CFG_LINE_LENGTH;
    cfg_data_i  <= len;
    @(posedge clk_i);
    length_reg = len;
    cfg_we_i   <= 1'b0;
  endtask

  // Result checker: one result per tick, no back-pressure.
  always @(posedge clk_i) begin
    scan_result_t want;
    if (rst_ni && result_strobe_o === 1'b1) begin
      if (pending_scans.size() == 0) begin
        $error("result beat with no tick outstanding");
        err_cnt++;
      end else begin
        want = pending_scans.pop_front();
        if (column_select_n_o !== want.sel_n) begin
          $error("column_select_n: expected %h, got %h", want.sel_n, column_select_n_o);
          err_cnt++;
        end
        if (row_bits_o !== want.rows) begin
          $error("row_bits: expected %h, got %h", want.rows, row_bits_o);
          err_cnt++;
        end
        if (frame_end_o !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, frame_end_o);
          err_cnt++;
        end
        if (scroll_wrapped_o !== want.wrapped) begin
          $error("scroll_wrapped: expected %b, got %b", want.wrapped, scroll_wrapped_o);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [8:0] reps;
    logic [8:0] len;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    req_type_i    = REQ_LOAD;
    load_index_i  = '0;
    column_data_i = '0;
    hold_i        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_FRAME_REPEATS;
    cfg_data_i    = '0;
    err_cnt       = 0;
    beat_cnt      = 0;
    cyc_cnt       = 0;
    scan_col      = '0;
    frames_shown  = '0;
    window_pos    = '0;
    repeats_reg   = 8'd10;
    length_reg    = 9'd8;
    for (int i = 0; i < LineDepth; i++) begin
      col_bytes[i]  = '0;
      col_loaded[i] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumDir; i++) begin
      idle_gap();
      send_beat(DirRows[i]);
    end

    for (int p = 0; p < NumPhases; p++) begin
      reps = PhRepeats[p];
      len  = PhLength[p];
      if (p == NumPhases - 1) begin
        reps = 9'($urandom_range(4, 1));
        len  = 9'($urandom_range(30, 8));
      end
      write_regs(reps, len);
      for (int n = 0; n < PhaseBeats; n++) begin
        idle_gap();
        send_beat(random_beat());
      end
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (err_cnt == 0 && pending_scans.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ led_matrix_scroll_scanner.f @@
hdl/lmss_pkg.sv
hdl/lmss_scan_ctrl.sv
hdl/led_matrix_scroll_scanner.sv
tb/tb_led_matrix_scroll_scanner.sv
